@@ sv/packed_4bpp_bitmap_blitter_macros.svh @@
// Assertion macros shared by the blitter's checker.
`ifndef PACKED_4BPP_BITMAP_BLITTER_MACROS_SVH
`define PACKED_4BPP_BITMAP_BLITTER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PBB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define PBB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/pbb_pkg.sv @@
// Types, register indexes and constants of the packed 4bpp bitmap blitter.
package pbb_pkg;

   localparam logic [3:0] NIBBLE_MASK = 4'hf;
   localparam logic [7:0] GRAY_SCALE  = 8'h11;

   typedef enum logic [2:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_BITMAP_WIDTH  = 3'd2,
      REG_BITMAP_HEIGHT = 3'd3,
      REG_KEY_ENABLE    = 3'd4,
      REG_KEY_COLOR     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] origin_x;
      logic [7:0] origin_y;
      logic [7:0] bitmap_width;
      logic [7:0] bitmap_height;
      logic       key_enable;
      logic [7:0] key_color;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] gray;
      logic       write_enable;
      logic       bitmap_done;
   } pixel_type;

   // Replicating the nibble into both halves is the same as nibble * 0x11.
   function automatic logic [7:0] gray_of(input logic [3:0] nibble);
      gray_of = 8'(nibble * GRAY_SCALE);
   endfunction

endpackage

@@ sv/pbb_csr.sv @@
// Configuration registers of the blitter, written through a plain write port.
module pbb_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output pbb_pkg::cfg_type  cfg
);

   pbb_pkg::cfg_type cfg_ff;
   pbb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pbb_pkg::REG_ORIGIN_X:      cfg_in.origin_x      = csr_wdata;
            pbb_pkg::REG_ORIGIN_Y:      cfg_in.origin_y      = csr_wdata;
            pbb_pkg::REG_BITMAP_WIDTH:  cfg_in.bitmap_width  = csr_wdata;
            pbb_pkg::REG_BITMAP_HEIGHT: cfg_in.bitmap_height = csr_wdata;
            pbb_pkg::REG_KEY_ENABLE:    cfg_in.key_enable    = csr_wdata[0];
            pbb_pkg::REG_KEY_COLOR:     cfg_in.key_color     = csr_wdata;
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= 8'd0;
         cfg_ff.origin_y      <= 8'd0;
         cfg_ff.bitmap_width  <= 8'd1;
         cfg_ff.bitmap_height <= 8'd1;
         cfg_ff.key_enable    <= 1'b0;
         cfg_ff.key_color     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/pbb_pixel.sv @@
// Raster position counters and the per-pixel gray, key and coordinate logic.
module pbb_pixel (
   input  logic                clock,
   input  logic                reset,
   input  pbb_pkg::cfg_type    cfg,
   input  logic                advance,
   input  logic [3:0]          nibble,
   output pbb_pkg::pixel_type  pixel
);

   logic [7:0] column_ff;
   logic [7:0] column_in;
   logic [7:0] row_ff;
   logic [7:0] row_in;
   logic [7:0] column_next;
   logic [7:0] row_next;
   logic       row_end;
   logic       frame_end;
   logic [7:0] gray;

   assign gray        = pbb_pkg::gray_of(nibble);
   assign column_next = column_ff + 8'd1;
   assign row_next    = row_ff + 8'd1;
   // A size of zero acts as 256 since the compare wraps with the counter.
   assign row_end     = (column_next == cfg.bitmap_width);
   assign frame_end   = row_end && (row_next == cfg.bitmap_height);

   always_comb begin
      pixel.pixel_x      = cfg.origin_x + column_ff;
      pixel.pixel_y      = cfg.origin_y + row_ff;
      pixel.gray         = gray;
      pixel.write_enable = !(cfg.key_enable && (gray == cfg.key_color));
      pixel.bitmap_done  = frame_end;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (row_end) begin
            column_in = 8'd0;
            row_in    = frame_end ? 8'd0 : row_next;
         end else begin
            column_in = column_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         row_ff    <= 8'd0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

@@ sv/packed_4bpp_bitmap_blitter.sv @@
// Packed 4bpp bitmap blitter: unpacks nibble pairs into keyed pixel writes with coordinates.
//
// Each accepted byte yields two pixel beats, low nibble first; a byte whose
// low nibble completes the bitmap yields one beat. The first beat of a byte
// passes through the input register and then the result register. Throughput
// is set by the single result register, which takes one pixel per cycle unless
// the result side stalls, while the input register holds the byte for its
// second nibble and takes the next byte in the same cycle that the last pixel
// of the current one moves out. Coordinates are the origin plus the column and
// row counters modulo 256; the counters return to zero after the last pixel of
// a bitmap. Configuration should be written only while no byte is in
// flight.
module packed_4bpp_bitmap_blitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packed_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [23:16] gray
   output logic [1:0]  rsp_tuser,   // [0] write_enable, [1] last_of_byte
   output logic        rsp_tlast,   // bitmap_done
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   pbb_pkg::cfg_type   cfg;
   pbb_pkg::pixel_type pixel;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       phase_ff;
   logic       phase_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   pbb_pkg::pixel_type rsp_pixel_ff;
   pbb_pkg::pixel_type rsp_pixel_in;
   logic       rsp_last_ff;
   logic       rsp_last_in;

   logic       step;
   logic       last_pixel;
   logic       accept;
   logic [3:0] nibble;

   pbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign nibble = phase_ff ? (in_byte_ff[7:4] & pbb_pkg::NIBBLE_MASK)
                            : (in_byte_ff[3:0] & pbb_pkg::NIBBLE_MASK);

   pbb_pixel u_pixel (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (step),
      .nibble  (nibble),
      .pixel   (pixel)
   );

   // A pixel moves into the result register whenever a byte is held and that
   // register is free or is being emptied in this cycle.
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   // The high nibble is dropped when the low nibble finishes the bitmap.
   assign last_pixel = phase_ff || pixel.bitmap_done;
   assign req_tready = !in_valid_ff || (step && last_pixel);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step && last_pixel) begin
         in_valid_in = 1'b0;
      end
      in_byte_in   = accept ? req_tdata : in_byte_ff;
      phase_in     = step ? !last_pixel : phase_ff;
      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_pixel_in = step ? pixel : rsp_pixel_ff;
      rsp_last_in  = step ? last_pixel : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pixel_ff.gray, rsp_pixel_ff.pixel_y, rsp_pixel_ff.pixel_x};
   assign rsp_tuser  = {rsp_last_ff, rsp_pixel_ff.write_enable};
   assign rsp_tlast  = rsp_pixel_ff.bitmap_done;

endmodule

@@ sv/pbb_checker.sv @@
// Port-level checker for the blitter and the bind that attaches it.
`include "packed_4bpp_bitmap_blitter_macros.svh"

module pbb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast
);

   // A stalled result beat keeps its contents.
   `PBB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")

   // The end of a bitmap always closes out the byte it came from.
   `PBB_ASSERT(a_done_ends_byte, rsp_tvalid && rsp_tlast |-> rsp_tuser[1], "bitmap end without last pixel of byte")

   // A cycle of reset leaves no result beat on offer.
   `PBB_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid right after reset")

   // A byte taken while the result register is empty is on offer once it has passed the input and result registers.
   `PBB_ASSERT(a_first_beat, req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid, "no result beat after accepted byte")

endmodule

bind packed_4bpp_bitmap_blitter pbb_checker u_pbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ test/packed_4bpp_bitmap_blitter_tb.sv @@
// Self-checking testbench for the packed 4bpp bitmap blitter with color key.
`timescale 1ns / 1ps

module packed_4bpp_bitmap_blitter_tb;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int NUM_PHASES = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS = 10;
   localparam longint LIMIT_NS = 40_000_000;

   typedef struct packed {
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] gray;
      logic       write_enable;
      logic       last_of_byte;
      logic       bitmap_done;
   } pixel_beat_type;

   // Tracks the blitter's registers and raster counters and holds the pixel
   // beats still owed by the block.
   class pixel_scoreboard_type;
      pixel_beat_type expected_pixels[$];
      logic [7:0]  origin_x, origin_y, width, height, key_color;
      logic        key_enable;
      logic [7:0]  column, row;
      int          failures;

      function new();
         origin_x   = 8'd0;
         origin_y   = 8'd0;
         width      = 8'd1;
         height     = 8'd1;
         key_enable = 1'b0;
         key_color  = 8'd0;
         column     = 8'd0;
         row        = 8'd0;
         failures   = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [7:0] value);
         case (index)
            pbb_pkg::REG_ORIGIN_X:      origin_x = value;
            pbb_pkg::REG_ORIGIN_Y:      origin_y = value;
            pbb_pkg::REG_BITMAP_WIDTH:  width = value;
            pbb_pkg::REG_BITMAP_HEIGHT: height = value;
            pbb_pkg::REG_KEY_ENABLE:    key_enable = value[0];
            pbb_pkg::REG_KEY_COLOR:     key_color = value;
            default: ;
         endcase
      endfunction

      // Builds the beat for one nibble at the current raster position and
      // advances the counters. A size of zero behaves as 256 on its own here.
      function pixel_beat_type place_pixel(logic [3:0] nibble);
         pixel_beat_type beat;
         beat.pixel_x      = origin_x + column;
         beat.pixel_y      = origin_y + row;
         beat.gray         = {nibble, nibble};
         beat.write_enable = !(key_enable && beat.gray == key_color);
         beat.last_of_byte = 1'b0;
         beat.bitmap_done  = 1'b0;
         if (8'(column + 8'd1) == width) begin
            column = 8'd0;
            if (8'(row + 8'd1) == height) begin
               row = 8'd0;
               beat.bitmap_done = 1'b1;
            end else begin
               row = row + 8'd1;
            end
         end else begin
            column = column + 8'd1;
         end
         return beat;
      endfunction

      function void note_byte(logic [7:0] packed_byte);
         pixel_beat_type beat;
         beat = place_pixel(packed_byte[3:0]);
         if (beat.bitmap_done) begin
            // The bitmap ended on the low nibble, so the high one is dropped.
            beat.last_of_byte = 1'b1;
            expected_pixels.push_back(beat);
            return;
         end
         expected_pixels.push_back(beat);
         beat = place_pixel(packed_byte[7:4]);
         beat.last_of_byte = 1'b1;
         expected_pixels.push_back(beat);
      endfunction

      function void check_pixel(logic [23:0] data, logic [1:0] user, logic last);
         pixel_beat_type got, want;
         got = '{data[7:0], data[15:8], data[23:16], user[0], user[1], last};
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected pixel beat: x=%0d y=%0d gray=%h we=%b lob=%b done=%b",
                        got.pixel_x, got.pixel_y, got.gray, got.write_enable,
                        got.last_of_byte, got.bitmap_done);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.gray !== want.gray || got.write_enable !== want.write_enable ||
             got.last_of_byte !== want.last_of_byte ||
             got.bitmap_done !== want.bitmap_done) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("pixel mismatch: expected x=%0d y=%0d gray=%h we=%b lob=%b done=%b, got x=%0d y=%0d gray=%h we=%b lob=%b done=%b",
                        want.pixel_x, want.pixel_y, want.gray, want.write_enable,
                        want.last_of_byte, want.bitmap_done,
                        got.pixel_x, got.pixel_y, got.gray, got.write_enable,
                        got.last_of_byte, got.bitmap_done);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [7:0]  csr_wdata = 8'd0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   pixel_scoreboard_type pixel_model;

   packed_4bpp_bitmap_blitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            pixel_model.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            pixel_model.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 87; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 87; end
         default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] packed_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= packed_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender off until every owed pixel has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixel_model.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      pixel_model.write_reg(index, value);
   endtask

   // The key enable word carries random upper bits that the block must mask off.
   task automatic apply_setting(input logic [7:0] ox, input logic [7:0] oy,
                                input logic [7:0] w, input logic [7:0] h,
                                input logic ke, input logic [7:0] kc);
      write_csr(CSR_SPARE_LO, 8'($urandom));
      write_csr(pbb_pkg::REG_ORIGIN_X, ox);
      write_csr(pbb_pkg::REG_ORIGIN_Y, oy);
      write_csr(pbb_pkg::REG_BITMAP_WIDTH, w);
      write_csr(pbb_pkg::REG_BITMAP_HEIGHT, h);
      write_csr(pbb_pkg::REG_KEY_ENABLE, {7'($urandom), ke});
      write_csr(pbb_pkg::REG_KEY_COLOR, kc);
      write_csr(CSR_SPARE_HI, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   // Mostly small bitmaps so that many of them complete, now and then an extreme.
   function automatic logic [7:0] pick_size();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'd255;
      if (roll < 5) return 8'($urandom_range(1, 40));
      return 8'($urandom_range(1, 8));
   endfunction

   initial begin
      logic [7:0] key;
      pixel_model = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // With the reset sizes every byte completes the bitmap on its low nibble.
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'ha5);
      drain();

      // Two bitmaps that wrap off the right and bottom screen edges, with keying.
      apply_setting(8'd254, 8'd255, 8'd3, 8'd2, 1'b1, 8'hff);
      send_byte(8'hf0);
      send_byte(8'h0f);
      send_byte(8'h5a);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'hc3);
      drain();

      // Key color matches but keying is off; then the width shrinks under a
      // column that is already past it.
      apply_setting(8'd0, 8'd0, 8'd5, 8'd3, 1'b0, 8'h00);
      send_byte(8'h00);
      send_byte(8'hf7);
      drain();
      apply_setting(8'd16, 8'd32, 8'd2, 8'd4, 1'b1, 8'h77);
      send_byte(8'h77);
      send_byte(8'h87);
      send_byte(8'he1);
      send_byte(8'h7d);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         set_idling(phase % 4);
         case (phase)
            0: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'h00);
            1: apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hff);
            default: begin
               key = ($urandom_range(3) == 0) ? 8'($urandom)
                                              : 8'(8'h11 * $urandom_range(15));
               apply_setting(8'($urandom), 8'($urandom), pick_size(), pick_size(),
                             1'($urandom), key);
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (pixel_model.pending() != 0);
            end
            send_byte(8'($urandom));
         end
         drain();
      end

      if (pixel_model.failures == 0 && pixel_model.pending() == 0) begin
         $display("packed_4bpp_bitmap_blitter_tb passed");
      end else begin
         $display("packed_4bpp_bitmap_blitter_tb failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("packed_4bpp_bitmap_blitter_tb failed");
      $finish;
   end

endmodule
